// ===== rtl/ndpa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the neuron dot product and activation block.
// Holds the shared widths, register indexes, activation mode codes and the queue entry type.
package ndpa_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int ACC_WIDTH  = 48;
   localparam int SUM_WIDTH  = ACC_WIDTH + 1;
   localparam int QUO_WIDTH  = FRAC_BITS + 1;
   localparam int CNT_WIDTH  = 4;
   localparam int MODE_WIDTH = 2;

   localparam logic REG_BIAS = 1'b0;
   localparam logic REG_MODE = 1'b1;

   localparam logic [MODE_WIDTH-1:0] MODE_NONE     = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SOFTSIGN = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RELU     = 2'd2;

   typedef struct packed {
      logic [ACC_WIDTH-1:0]  sum;
      logic [DATA_WIDTH-1:0] bias;
      logic [MODE_WIDTH-1:0] mode;
   } ndpa_job_type;

endpackage

// ===== rtl/neuron_dot_product_activation_top.sv =====
`timescale 1ns / 1ps
// Neuron evaluation: multiply-accumulate, bias, and identity, ReLU or softsign activation.
// The front end takes one transaction per cycle, except while a last item waits on a full queue.
// The back end takes one neuron at a time and takes longer for softsign, set by the
// one-bit-per-cycle divider; a two-entry queue decouples the two ends.
// Synchronous reset clears the accumulator, the queue, the bias and the mode to zero.
module neuron_dot_product_activation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // prev_output [15:0], weight [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // neuron_output [15:0]
   output logic        rsp_tuser,   // saturated [0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [ndpa_pkg::DATA_WIDTH-1:0] bias_ff, bias_in;
   logic [ndpa_pkg::MODE_WIDTH-1:0] mode_ff, mode_in;
   logic                            wr_en;
   logic                            queue_full;
   logic                            queue_empty;
   logic                            push;
   logic                            pop;
   ndpa_pkg::ndpa_job_type          push_job;
   ndpa_pkg::ndpa_job_type          pop_job;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      bias_in = bias_ff;
      mode_in = mode_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            ndpa_pkg::REG_BIAS: bias_in = csr_pwdata[ndpa_pkg::DATA_WIDTH-1:0];
            ndpa_pkg::REG_MODE: mode_in = csr_pwdata[ndpa_pkg::MODE_WIDTH-1:0];
            default:  bias_in = bias_ff;
         endcase
      end
      case (csr_paddr[2])
         ndpa_pkg::REG_BIAS: csr_prdata = {16'b0, bias_ff};
         ndpa_pkg::REG_MODE: csr_prdata = {30'b0, mode_ff};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
         mode_ff <= ndpa_pkg::MODE_NONE;
      end else begin
         bias_ff <= bias_in;
         mode_ff <= mode_in;
      end
   end

   ndpa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .prev_output     (req_tdata[15:0]),
      .weight          (req_tdata[31:16]),
      .last            (req_tlast),
      .bias            (bias_ff),
      .activation_mode (mode_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   ndpa_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   ndpa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .job           (pop_job),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .neuron_output (rsp_tdata),
      .saturated     (rsp_tuser)
   );

endmodule

// ===== rtl/ndpa_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, registers each product and accumulates.
// On the last item it pushes the sum with bias and mode into the job queue. Uses ndpa_pkg.
module ndpa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [ndpa_pkg::DATA_WIDTH-1:0] prev_output,
   input  logic signed [ndpa_pkg::DATA_WIDTH-1:0] weight,
   input  logic                                last,
   input  logic [ndpa_pkg::DATA_WIDTH-1:0]     bias,
   input  logic [ndpa_pkg::MODE_WIDTH-1:0]     activation_mode,
   input  logic                                queue_full,
   output logic                                push,
   output ndpa_pkg::ndpa_job_type              push_job
);

   logic signed [ndpa_pkg::PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                                   pvalid_ff, pvalid_in;
   logic                                   plast_ff, plast_in;
   logic [ndpa_pkg::ACC_WIDTH-1:0]         acc_ff, acc_in;
   logic [ndpa_pkg::ACC_WIDTH-1:0]         sum;
   logic                                   advance;
   logic                                   take;

   assign advance  = pvalid_ff && (!plast_ff || !queue_full);
   assign in_ready = !pvalid_ff || advance;
   assign take     = in_valid && in_ready;
   assign sum      = acc_ff + {{(ndpa_pkg::ACC_WIDTH - ndpa_pkg::PROD_WIDTH){prod_ff[ndpa_pkg::PROD_WIDTH-1]}},
                               prod_ff};
   assign push     = advance && plast_ff;

   always_comb begin
      push_job.sum  = sum;
      push_job.bias = bias;
      push_job.mode = activation_mode;
      prod_in   = prod_ff;
      plast_in  = plast_ff;
      pvalid_in = pvalid_ff;
      acc_in    = acc_ff;
      if (advance) begin
         pvalid_in = 1'b0;
         acc_in    = plast_ff ? '0 : sum;
      end
      if (take) begin
         prod_in   = prev_output * weight;
         plast_in  = last;
         pvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         pvalid_ff <= pvalid_in;
         acc_ff    <= acc_in;
      end
      prod_ff  <= prod_in;
      plast_ff <= plast_in;
   end

endmodule

// ===== rtl/ndpa_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between the accumulating front end and the activation back end.
// Uses the job type from ndpa_pkg.
module ndpa_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ndpa_pkg::ndpa_job_type push_job,
   input  logic                   pop,
   output ndpa_pkg::ndpa_job_type pop_job,
   output logic                   full,
   output logic                   empty
);

   ndpa_pkg::ndpa_job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/ndpa_back.sv =====
`timescale 1ns / 1ps
// Back end: adds the bias, applies identity, ReLU or softsign and holds the result.
// Softsign uses a restoring divider that produces one quotient bit per cycle. Uses ndpa_pkg.
module ndpa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  ndpa_pkg::ndpa_job_type              job,
   output logic                                pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ndpa_pkg::DATA_WIDTH-1:0]     neuron_output,
   output logic                                saturated
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int SW = ndpa_pkg::SUM_WIDTH;
   localparam int DW = ndpa_pkg::DATA_WIDTH;
   localparam int QW = ndpa_pkg::QUO_WIDTH;
   localparam int YW = SW + 1 - ndpa_pkg::FRAC_BITS;
   localparam logic [SW-1:0] DEN_ONE  = SW'(1) << (2 * ndpa_pkg::FRAC_BITS);
   localparam logic [SW:0]   HALF_LSB = (SW + 1)'(1) << (ndpa_pkg::FRAC_BITS - 1);
   localparam logic [ndpa_pkg::CNT_WIDTH-1:0] LAST_STEP = ndpa_pkg::CNT_WIDTH'(ndpa_pkg::FRAC_BITS);

   logic [1:0]                        state_ff, state_in;
   logic [SW-1:0]                     x_ff, x_in;
   logic [ndpa_pkg::MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic                              neg_ff, neg_in;
   logic [SW-1:0]                     den_ff, den_in;
   logic [SW-1:0]                     rem_ff, rem_in;
   logic [QW-1:0]                     quo_ff, quo_in;
   logic [ndpa_pkg::CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [DW-1:0]                     res_ff, res_in;
   logic                              rsat_ff, rsat_in;
   logic                              ovalid_ff, ovalid_in;
   logic [DW-1:0]                     odata_ff, odata_in;
   logic                              osat_ff, osat_in;

   logic [SW:0]   rounded;
   logic [YW-1:0] y;
   logic          fits;
   logic [SW:0]   shifted;
   logic          ge;
   logic [QW-1:0] quo_final;
   logic          load_out;

   assign pop           = (state_ff == ST_IDLE) && !queue_empty;
   assign out_valid     = ovalid_ff;
   assign neuron_output = odata_ff;
   assign saturated     = osat_ff;
   assign load_out      = (state_ff == ST_DONE) && (!ovalid_ff || out_ready);

   assign rounded   = {x_ff[SW-1], x_ff} + HALF_LSB;
   assign y         = rounded[SW:ndpa_pkg::FRAC_BITS];
   assign fits      = (y[YW-1:DW-1] == '0) || (y[YW-1:DW-1] == '1);
   assign shifted   = {rem_ff, 1'b0};
   assign ge        = shifted >= {1'b0, den_ff};
   assign quo_final = quo_ff + QW'(ge);

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      rsat_in   = rsat_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      osat_in   = osat_ff;
      if (ovalid_ff && out_ready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               x_in     = {job.sum[ndpa_pkg::ACC_WIDTH-1], job.sum}
                          + {{(SW - DW - ndpa_pkg::FRAC_BITS){job.bias[DW-1]}}, job.bias,
                             {ndpa_pkg::FRAC_BITS{1'b0}}};
               mode_in  = job.mode;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in = x_ff[SW-1];
            rem_in = x_ff[SW-1] ? (SW'(0) - x_ff) : x_ff;
            den_in = x_ff[SW-1] ? (DEN_ONE - x_ff) : (DEN_ONE + x_ff);
            quo_in = '0;
            cnt_in = '0;
            if (mode_ff == ndpa_pkg::MODE_SOFTSIGN) begin
               state_in = ST_DIV;
            end else begin
               if (mode_ff == ndpa_pkg::MODE_RELU &&
                   (x_ff[SW-1] || x_ff == '0)) begin
                  res_in  = '0;
                  rsat_in = 1'b0;
               end else if (fits) begin
                  res_in  = y[DW-1:0];
                  rsat_in = 1'b0;
               end else begin
                  res_in  = y[YW-1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
                  rsat_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (cnt_ff == LAST_STEP) begin
               res_in   = neg_ff ? DW'(-{{(DW - QW){1'b0}}, quo_final})
                                 : {{(DW - QW){1'b0}}, quo_final};
               rsat_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               rem_in = ge ? SW'(shifted - {1'b0, den_ff}) : shifted[SW-1:0];
               quo_in = {quo_ff[QW-2:0], ge};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               ovalid_in = 1'b1;
               odata_in  = res_ff;
               osat_in   = rsat_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      x_ff     <= x_in;
      mode_ff  <= mode_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      rsat_ff  <= rsat_in;
      odata_ff <= odata_in;
      osat_ff  <= osat_in;
   end

endmodule
